/* sv/kvls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kvls_pkg;

   localparam int MAX_KEYS_DEFAULT = 64;

   localparam int TIME_W  = 32;
   localparam int VAL_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // Weight is an unsigned Q0.16 fraction.
   localparam int WEIGHT_W = 16;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Register index as decoded from paddr[2].
   localparam logic REG_KEY_COUNT = 1'b0;

   localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = COUNT_W'(1);

endpackage

`default_nettype wire

/* sv/kvls_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface kvls_req_if
   import kvls_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [SLOT_W-1:0] key_slot;
   logic [TIME_W-1:0] key_time;
   logic [VAL_W-1:0]  value_x;
   logic [VAL_W-1:0]  value_y;
   logic [VAL_W-1:0]  value_z;
   logic [TIME_W-1:0] sample_time;

   modport source (
      output valid, kind, key_slot, key_time, value_x, value_y, value_z, sample_time,
      input  ready
   );
   modport sink (
      input  valid, kind, key_slot, key_time, value_x, value_y, value_z, sample_time,
      output ready
   );
endinterface

interface kvls_rsp_if
   import kvls_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] out_x;
   logic [VAL_W-1:0] out_y;
   logic [VAL_W-1:0] out_z;
   logic             held;

   modport source (
      output valid, out_x, out_y, out_z, held,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, held,
      output ready
   );
endinterface

`default_nettype wire

/* sv/keyframe_vector_lerp_sampler.sv */
// Load transfer: accepted with no result; the block stays ready.
// Sample transfer: the result is an interpolation, or a stored key returned as it is. N is
// the effective key count, at most MAX_KEYS. The work is done by the linear key search (one
// RAM read a cycle), the 16-step restoring divider and one shared multiplier run three
// times. One sample at a time.
// Reset (synchronous) clears the sequencer and sets key_count to 1; the key RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_vector_lerp_sampler
   import kvls_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   kvls_req_if.sink                req_ch,
   kvls_rsp_if.source              rsp_ch,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output      logic [PDATA_W-1:0] prdata,
   output      logic               pready
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int KW = $clog2(MAX_KEYS + 1);
   localparam int CW = (KW > COUNT_W) ? KW : COUNT_W;
   localparam int RW = TIME_W + 3 * VAL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_PICK, ST_LOAD_A, ST_LOAD_B,
      ST_DIV, ST_SUB, ST_MUL, ST_ADD, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] key_count_ff;

   logic [TIME_W-1:0] t_ff, t_in;
   logic [TIME_W-1:0] t0_ff, t0_in;
   logic [TIME_W-1:0] dt_ff, dt_in;
   logic [KW-1:0]     n_ff, n_in;
   logic [KW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic [AW-1:0]     sel_ff, sel_in;
   logic              found_ff, found_in;
   logic              held_ff, held_in;

   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [TIME_W-1:0]   dvs_ff, dvs_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [3:0]          div_cnt_ff, div_cnt_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;

   logic [2:0][VAL_W-1:0] a_ff, a_in;
   logic [2:0][VAL_W-1:0] b_ff, b_in;
   logic [2:0][VAL_W-1:0] res_ff, res_in;
   logic [1:0]            comp_ff, comp_in;
   logic signed [VAL_W:0] diff_ff, diff_in;
   logic signed [VAL_W+WEIGHT_W+1:0] prod_ff, prod_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] out_x_ff, out_x_in;
   logic [VAL_W-1:0] out_y_ff, out_y_in;
   logic [VAL_W-1:0] out_z_ff, out_z_in;
   logic             out_held_ff, out_held_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_data;
   logic [TIME_W-1:0] rd_time;

   logic [CW-1:0] count_w;
   logic [KW-1:0] n_eff;
   logic          slot_ok;
   logic          held_now;
   logic [TIME_W:0]   rem_shift;
   logic              rem_ge;
   logic [TIME_W-1:0] span;

   // Each RAM word holds {time, z, y, x} of one key.
   kvls_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time = rd_data[RW-1 -: TIME_W];

   // Configuration port.
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_KEY_COUNT) begin
         prdata = PDATA_W'(key_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KEY_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEY_COUNT) begin
         key_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // A count of zero acts as one, and anything above the track size is clamped.
   always_comb begin
      count_w = CW'(key_count_ff);
      if (key_count_ff == '0) begin
         n_eff = KW'(1);
      end else if (count_w > CW'(MAX_KEYS)) begin
         n_eff = KW'(MAX_KEYS);
      end else begin
         n_eff = KW'(count_w);
      end
   end

   assign slot_ok  = 32'(req_ch.key_slot) < 32'(MAX_KEYS);
   assign wr_addr  = AW'(req_ch.key_slot);
   assign wr_data  = {req_ch.key_time, req_ch.value_z, req_ch.value_y, req_ch.value_x};
   assign held_now = (n_ff == KW'(1)) || !found_ff || (KW'(sel_ff) == n_ff - KW'(1));

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, dvs_ff};
   assign span      = rd_time - t0_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      t0_in        = t0_ff;
      dt_in        = dt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      sel_in       = sel_ff;
      found_in     = found_ff;
      held_in      = held_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      q_in         = q_ff;
      div_cnt_in   = div_cnt_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      comp_in      = comp_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_held_in  = out_held_ff;
      wr_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == KIND_LOAD) begin
                  wr_en = slot_ok;
               end else begin
                  t_in     = req_ch.sample_time;
                  n_in     = n_eff;
                  idx_in   = '0;
                  sel_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // One read is issued per cycle; its time is compared in the next cycle.
            if (idx_ff != n_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + KW'(1);
            end
            if (pend_ff && rd_time <= t_ff) begin
               sel_in   = pidx_ff;
               found_in = 1'b1;
            end
            if (idx_ff == n_ff && !pend_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            held_in = held_now;
            if (!found_ff) begin
               sel_in = '0;
            end
            rd_addr  = found_ff ? sel_ff : '0;
            state_in = ST_LOAD_A;
         end
         ST_LOAD_A: begin
            rd_addr = sel_ff + AW'(1);
            t0_in   = rd_time;
            dt_in   = t_ff - rd_time;
            a_in[0] = rd_data[VAL_W-1:0];
            a_in[1] = rd_data[2*VAL_W-1 -: VAL_W];
            a_in[2] = rd_data[3*VAL_W-1 -: VAL_W];
            if (held_ff) begin
               res_in[0] = rd_data[VAL_W-1:0];
               res_in[1] = rd_data[2*VAL_W-1 -: VAL_W];
               res_in[2] = rd_data[3*VAL_W-1 -: VAL_W];
               state_in  = ST_DONE;
            end else begin
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            b_in[0]    = rd_data[VAL_W-1:0];
            b_in[1]    = rd_data[2*VAL_W-1 -: VAL_W];
            b_in[2]    = rd_data[3*VAL_W-1 -: VAL_W];
            comp_in    = 2'd0;
            rem_in     = dt_ff;
            dvs_in     = span;
            q_in       = '0;
            div_cnt_in = 4'd15;
            if (rd_time <= t0_ff) begin
               w_in     = '0;
               state_in = ST_SUB;
            end else if (dt_ff >= span) begin
               w_in     = '1;
               state_in = ST_SUB;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division; the remainder stays below the divisor.
            if (rem_ge) begin
               rem_in = TIME_W'(rem_shift - {1'b0, dvs_ff});
            end else begin
               rem_in = rem_shift[TIME_W-1:0];
            end
            q_in       = {q_ff[WEIGHT_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff - 4'd1;
            if (div_cnt_ff == 4'd0) begin
               w_in     = q_in;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            diff_in  = $signed({b_ff[comp_ff][VAL_W-1], b_ff[comp_ff]})
                     - $signed({a_ff[comp_ff][VAL_W-1], a_ff[comp_ff]});
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = diff_ff * $signed({1'b0, w_ff});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // The arithmetic shift by 16 floors toward minus infinity.
            res_in[comp_ff] = a_ff[comp_ff] + prod_ff[VAL_W+WEIGHT_W-1:WEIGHT_W];
            if (comp_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_SUB;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = res_ff[0];
               out_y_in     = res_ff[1];
               out_z_in     = res_ff[2];
               out_held_in  = held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= KW'(1);
         found_ff     <= 1'b0;
         held_ff      <= 1'b0;
         comp_ff      <= 2'd0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         held_ff      <= held_in;
         comp_ff      <= comp_in;
         div_cnt_ff   <= div_cnt_in;
      end
      t_ff        <= t_in;
      t0_ff       <= t0_in;
      dt_ff       <= dt_in;
      pidx_ff     <= pidx_in;
      sel_ff      <= sel_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      q_ff        <= q_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      res_ff      <= res_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_held_ff <= out_held_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.out_z = out_z_ff;
   assign rsp_ch.held  = out_held_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.kind == KIND_LOAD) |=> !$rose(rsp_ch.valid))
      else $error("a load transfer produced a result");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.kind == KIND_SAMPLE) |=> !req_ch.ready)
      else $error("block still ready after accepting a sample");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (idx_ff <= n_ff))
      else $error("search index ran past the key count");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* sv/kvls_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module kvls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
